// ----- rtl/btha_pkg.sv -----
// Shared types and constants of the boundary-tag heap allocator.
`default_nettype none
package btha_pkg;
    localparam int unsigned TAG_W = 32;
    localparam int unsigned ADDR_W = 13;
    localparam int unsigned OFF_W = 12;

    typedef logic [TAG_W-1:0] t_tag;
    typedef logic [ADDR_W-1:0] t_addr;

    // Item kinds.
    localparam logic [1:0] KIND_FORMAT = 2'd0;
    localparam logic [1:0] KIND_ALLOC = 2'd1;
    localparam logic [1:0] KIND_FREE = 2'd2;
    localparam logic [1:0] KIND_CHECK = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_UNFORMATTED = 3'd1;
    localparam logic [2:0] ST_BAD_MARKER = 3'd2;
    localparam logic [2:0] ST_BAD_SIZE = 3'd3;
    localparam logic [2:0] ST_BAD_TAIL = 3'd4;
    localparam logic [2:0] ST_NO_FIT = 3'd5;
    localparam logic [2:0] ST_NOT_USED = 3'd6;
    localparam logic [2:0] ST_BAD_REQ = 3'd7;

    localparam logic [ADDR_W-1:0] MIN_HEAP = 13'd5;

    // Write and read port bundle from the sequencer to the tag memory.
    typedef struct packed {
        logic  we;
        t_addr waddr;
        t_tag  wdata;
        t_addr raddr;
    } t_mem_req;
endpackage
`default_nettype wire

// ----- rtl/btha_ram.sv -----
// Tag memory: one write port and one read port with registered read data.
`default_nettype none
module btha_ram #(
    parameter int unsigned HEAP_DEPTH = 4096
) (
    input  wire               i_clk,
    input  btha_pkg::t_mem_req i_req,
    output btha_pkg::t_tag    o_rdata
);
    localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;

    btha_pkg::t_tag r_mem [HEAP_DEPTH];
    btha_pkg::t_tag r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[AW'(i_req.waddr)] <= i_req.wdata;
        end
        r_rdata <= r_mem[AW'(i_req.raddr)];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ----- rtl/boundary_tag_heap_allocator.sv -----
// Top level: sequencer that walks the block chain through the tag memory.
// Items walk the tag memory through its single read port: format writes the heap header,
// one free block and the end marker; free reads the head and tail of the block; check reads
// both tags of every block; allocate walks the chain, merging free neighbours and splitting.
// One item at a time: the next item is taken the cycle after the result enters the output register.
// Synchronous active-low reset clears control state; the heap is unformatted after it.
`default_nettype none
module boundary_tag_heap_allocator #(
    parameter int unsigned HEAP_DEPTH = 4096,
    parameter int unsigned SPLIT_SLACK = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire [12:0] i_cfg_data,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire [1:0]  i_kind,
    input  wire [11:0] i_request_words,
    input  wire [11:0] i_block_offset,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic [2:0] o_status,
    output logic [11:0] o_granted_offset,
    output logic [10:0] o_free_block_count,
    output logic [11:0] o_free_payload_words,
    output logic [10:0] o_used_block_count,
    output logic [11:0] o_used_payload_words
);
    localparam logic [12:0] HEAP_CAP = (HEAP_DEPTH < 4096) ? 13'(HEAP_DEPTH) : 13'd4096;
    localparam logic [13:0] SLACK = 14'(SPLIT_SLACK);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FMT = 4'd1;
    localparam logic [3:0] S_LIM = 4'd2;
    localparam logic [3:0] S_MARK = 4'd3;
    localparam logic [3:0] S_WALK = 4'd4;
    localparam logic [3:0] S_HEAD = 4'd5;
    localparam logic [3:0] S_TAIL = 4'd6;
    localparam logic [3:0] S_MRG = 4'd7;
    localparam logic [3:0] S_MRGV = 4'd8;
    localparam logic [3:0] S_MRGW = 4'd9;
    localparam logic [3:0] S_FIT = 4'd10;
    localparam logic [3:0] S_SPL = 4'd11;
    localparam logic [3:0] S_FHEAD = 4'd12;
    localparam logic [3:0] S_FTAIL = 4'd13;
    localparam logic [3:0] S_DONE = 4'd14;

    logic [3:0]  r_state, n_state;
    logic [1:0]  r_kind, n_kind;
    logic [11:0] r_req, n_req;
    logic [11:0] r_off, n_off;
    logic [11:0] r_limit, n_limit;
    logic [12:0] r_cur, n_cur;
    logic [12:0] r_sz, n_sz;
    logic [12:0] r_nxt, n_nxt;
    logic [1:0]  r_wcnt, n_wcnt;
    logic [2:0]  r_st, n_st;
    logic [11:0] r_gnt, n_gnt;
    logic [10:0] r_fb, n_fb;
    logic [11:0] r_fw, n_fw;
    logic [10:0] r_ub, n_ub;
    logic [11:0] r_uw, n_uw;
    logic        r_fmt, n_fmt;
    logic [12:0] r_hw;
    logic        r_ov;
    logic [2:0]  r_o_st;
    logic [11:0] r_o_gnt;
    logic [10:0] r_o_fb;
    logic [11:0] r_o_fw;
    logic [10:0] r_o_ub;
    logic [11:0] r_o_uw;

    btha_pkg::t_mem_req mem_req;
    btha_pkg::t_tag     q;
    logic [31:0] mag;
    logic [32:0] reach;
    logic        too_far;
    logic [12:0] need, diff, nsat, nlim;
    logic [31:0] qn;
    logic        in_acc, load_out;

    btha_ram #(.HEAP_DEPTH(HEAP_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_req  (mem_req),
        .o_rdata(q)
    );

    assign in_acc = i_in_valid && o_in_ready;
    assign load_out = (r_state == S_DONE) && (!r_ov || i_out_ready);

    // Shared magnitude and end-of-block compare used by both head tag checks, plus the heap size clamps.
    always_comb begin
        mag = q[31] ? (~q + 32'd1) : q;
        reach = {20'd0, r_cur} + {1'b0, mag};
        too_far = (mag < 32'd3) || (reach > {21'd0, r_limit});
        need = {1'b0, r_req} + 13'd2;
        diff = r_sz - need;
        qn = q;
        if ($signed(qn) > $signed({19'd0, HEAP_CAP})) begin
            nlim = HEAP_CAP;
        end else if ($signed(qn) < $signed({19'd0, btha_pkg::MIN_HEAP})) begin
            nlim = btha_pkg::MIN_HEAP;
        end else begin
            nlim = qn[12:0];
        end
        if (r_hw > HEAP_CAP) begin
            nsat = HEAP_CAP;
        end else if (r_hw < btha_pkg::MIN_HEAP) begin
            nsat = btha_pkg::MIN_HEAP;
        end else begin
            nsat = r_hw;
        end
    end

    always_comb begin
        n_state = r_state;
        n_kind = r_kind;
        n_req = r_req;
        n_off = r_off;
        n_limit = r_limit;
        n_cur = r_cur;
        n_sz = r_sz;
        n_nxt = r_nxt;
        n_wcnt = r_wcnt;
        n_st = r_st;
        n_gnt = r_gnt;
        n_fb = r_fb;
        n_fw = r_fw;
        n_ub = r_ub;
        n_uw = r_uw;
        n_fmt = r_fmt;
        mem_req = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_kind = i_kind;
                    n_req = i_request_words;
                    n_off = i_block_offset;
                    n_st = btha_pkg::ST_OK;
                    n_wcnt = 2'd0;
                    mem_req.raddr = 13'd0;
                    if (i_kind == btha_pkg::KIND_FORMAT) begin
                        n_cur = nsat;
                        n_state = S_FMT;
                    end else if (!r_fmt) begin
                        n_st = btha_pkg::ST_UNFORMATTED;
                        n_state = S_DONE;
                    end else if (i_kind == btha_pkg::KIND_ALLOC && i_request_words == 12'd0) begin
                        n_st = btha_pkg::ST_BAD_REQ;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_LIM;
                    end
                end
            end
            S_FMT: begin
                mem_req.we = 1'b1;
                case (r_wcnt)
                    2'd0: begin
                        mem_req.waddr = 13'd0;
                        mem_req.wdata = {19'd0, r_cur};
                    end
                    2'd1: begin
                        mem_req.waddr = 13'd1;
                        mem_req.wdata = {19'd0, r_cur - 13'd2};
                    end
                    2'd2: begin
                        mem_req.waddr = r_cur - 13'd2;
                        mem_req.wdata = {19'd0, r_cur - 13'd2};
                    end
                    default: begin
                        mem_req.waddr = r_cur - 13'd1;
                        mem_req.wdata = 32'd0;
                    end
                endcase
                n_wcnt = r_wcnt + 2'd1;
                if (r_wcnt == 2'd3) begin
                    n_fmt = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_LIM: begin
                n_limit = 12'(nlim - 13'd1);
                if (r_kind == btha_pkg::KIND_FREE) begin
                    n_cur = {1'b0, r_off - 12'd1};
                    if (r_off < 12'd2 || (r_off - 12'd1) >= 12'(nlim - 13'd1)) begin
                        n_st = btha_pkg::ST_NOT_USED;
                        n_state = S_DONE;
                    end else begin
                        mem_req.raddr = {1'b0, r_off - 12'd1};
                        n_state = S_FHEAD;
                    end
                end else begin
                    mem_req.raddr = nlim - 13'd1;
                    n_state = S_MARK;
                end
            end
            S_MARK: begin
                if ($signed(q) < -32'sd1 || $signed(q) > 32'sd1) begin
                    n_st = btha_pkg::ST_BAD_MARKER;
                    n_state = S_DONE;
                end else begin
                    n_cur = 13'd1;
                    n_fb = '0;
                    n_fw = '0;
                    n_ub = '0;
                    n_uw = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_cur < {1'b0, r_limit}) begin
                    mem_req.raddr = r_cur;
                    n_state = S_HEAD;
                end else begin
                    n_st = (r_kind == btha_pkg::KIND_ALLOC) ? btha_pkg::ST_NO_FIT : btha_pkg::ST_OK;
                    n_state = S_DONE;
                end
            end
            S_HEAD: begin
                n_sz = mag[12:0];
                if (q == 32'd0) begin
                    n_st = (r_kind == btha_pkg::KIND_ALLOC) ? btha_pkg::ST_NO_FIT : btha_pkg::ST_OK;
                    n_state = S_DONE;
                end else if (too_far) begin
                    n_st = btha_pkg::ST_BAD_SIZE;
                    n_state = S_DONE;
                end else if (r_kind == btha_pkg::KIND_CHECK) begin
                    mem_req.raddr = reach[12:0] - 13'd1;
                    n_state = S_TAIL;
                end else if (q[31]) begin
                    n_cur = reach[12:0];
                    n_state = S_WALK;
                end else begin
                    n_nxt = reach[12:0];
                    n_state = S_MRG;
                end
            end
            S_TAIL: begin
                if (q != {19'd0, r_sz}) begin
                    n_st = btha_pkg::ST_BAD_TAIL;
                    n_state = S_DONE;
                end else begin
                    // The sign of the head tag was dropped; the used flag is re-read.
                    n_state = S_WALK;
                    n_cur = r_cur + r_sz;
                    mem_req.raddr = r_cur;
                    n_state = S_FIT;
                end
            end
            S_MRG: begin
                if (r_nxt < {1'b0, r_limit}) begin
                    mem_req.raddr = r_nxt;
                    n_state = S_MRGV;
                end else begin
                    n_state = S_FIT;
                end
            end
            S_MRGV: begin
                if ($signed(q) > 32'sd2) begin
                    if ({20'd0, r_nxt} + {1'b0, q} > {21'd0, r_limit}) begin
                        n_st = btha_pkg::ST_BAD_SIZE;
                        n_state = S_DONE;
                    end else begin
                        n_sz = r_sz + q[12:0];
                        mem_req.we = 1'b1;
                        mem_req.waddr = r_cur;
                        mem_req.wdata = {19'd0, r_sz + q[12:0]};
                        n_state = S_MRGW;
                    end
                end else begin
                    n_state = S_FIT;
                end
            end
            S_MRGW: begin
                mem_req.we = 1'b1;
                mem_req.waddr = r_cur + r_sz - 13'd1;
                mem_req.wdata = {19'd0, r_sz};
                n_nxt = r_cur + r_sz;
                n_state = S_MRG;
            end
            S_FIT: begin
                if (r_kind == btha_pkg::KIND_CHECK) begin
                    // Check path: q holds the head tag read again in S_TAIL.
                    if (q[31]) begin
                        n_ub = r_ub + 11'd1;
                        n_uw = r_uw + 12'(r_sz - 13'd2);
                    end else begin
                        n_fb = r_fb + 11'd1;
                        n_fw = r_fw + 12'(r_sz - 13'd2);
                    end
                    n_state = S_WALK;
                end else if (need <= r_sz) begin
                    n_gnt = 12'(r_cur + 13'd1);
                    if ({1'b0, diff} > SLACK) begin
                        n_wcnt = 2'd0;
                        n_state = S_SPL;
                    end else begin
                        mem_req.we = 1'b1;
                        mem_req.waddr = r_cur;
                        mem_req.wdata = ~{19'd0, r_sz} + 32'd1;
                        n_st = btha_pkg::ST_OK;
                        n_state = S_DONE;
                    end
                end else begin
                    n_cur = r_cur + r_sz;
                    n_state = S_WALK;
                end
            end
            S_SPL: begin
                mem_req.we = 1'b1;
                case (r_wcnt)
                    2'd0: begin
                        mem_req.waddr = r_cur;
                        mem_req.wdata = ~{19'd0, need} + 32'd1;
                    end
                    2'd1: begin
                        mem_req.waddr = r_cur + need - 13'd1;
                        mem_req.wdata = {19'd0, need};
                    end
                    2'd2: begin
                        mem_req.waddr = r_cur + need;
                        mem_req.wdata = {19'd0, diff};
                    end
                    default: begin
                        mem_req.waddr = r_cur + r_sz - 13'd1;
                        mem_req.wdata = {19'd0, diff};
                    end
                endcase
                n_wcnt = r_wcnt + 2'd1;
                if (r_wcnt == 2'd3) begin
                    n_st = btha_pkg::ST_OK;
                    n_state = S_DONE;
                end
            end
            S_FHEAD: begin
                n_sz = mag[12:0];
                if (!q[31]) begin
                    n_st = btha_pkg::ST_NOT_USED;
                    n_state = S_DONE;
                end else if (too_far) begin
                    n_st = btha_pkg::ST_BAD_SIZE;
                    n_state = S_DONE;
                end else begin
                    mem_req.raddr = reach[12:0] - 13'd1;
                    n_state = S_FTAIL;
                end
            end
            S_FTAIL: begin
                if (q != {19'd0, r_sz}) begin
                    n_st = btha_pkg::ST_BAD_TAIL;
                end else begin
                    mem_req.we = 1'b1;
                    mem_req.waddr = r_cur;
                    mem_req.wdata = {19'd0, r_sz};
                    n_st = btha_pkg::ST_OK;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fmt <= 1'b0;
            r_hw <= 13'd4096;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fmt <= n_fmt;
            if (i_cfg_we) begin
                r_hw <= i_cfg_data;
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_req <= n_req;
        r_off <= n_off;
        r_limit <= n_limit;
        r_cur <= n_cur;
        r_sz <= n_sz;
        r_nxt <= n_nxt;
        r_wcnt <= n_wcnt;
        r_st <= n_st;
        r_gnt <= n_gnt;
        r_fb <= n_fb;
        r_fw <= n_fw;
        r_ub <= n_ub;
        r_uw <= n_uw;
        if (load_out) begin
            r_o_st <= r_st;
            r_o_gnt <= (r_kind == btha_pkg::KIND_ALLOC && r_st == btha_pkg::ST_OK) ? r_gnt : 12'd0;
            if (r_kind == btha_pkg::KIND_CHECK && r_st == btha_pkg::ST_OK) begin
                r_o_fb <= r_fb;
                r_o_fw <= r_fw;
                r_o_ub <= r_ub;
                r_o_uw <= r_uw;
            end else begin
                r_o_fb <= '0;
                r_o_fw <= '0;
                r_o_ub <= '0;
                r_o_uw <= '0;
            end
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_out_valid = r_ov;
    assign o_status = r_o_st;
    assign o_granted_offset = r_o_gnt;
    assign o_free_block_count = r_o_fb;
    assign o_free_payload_words = r_o_fw;
    assign o_used_block_count = r_o_ub;
    assign o_used_payload_words = r_o_uw;
endmodule
`default_nettype wire

// ----- rtl/btha_checker.sv -----
// Port-level checker for the allocator and its bind to the top level.
`default_nettype none
module btha_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_ready,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire [2:0]  o_status,
    input wire [11:0] o_granted_offset,
    input wire [10:0] o_free_block_count,
    input wire [10:0] o_used_block_count
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != btha_pkg::ST_OK |-> o_granted_offset == 12'd0)
        else $error("failed item shows a granted offset");

    a_grant_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_granted_offset != 12'd0 |-> o_granted_offset >= 12'd2)
        else $error("granted offset lies inside the heap header");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken while one is in work");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_granted_offset != 12'd0 |->
            o_free_block_count == 11'd0 && o_used_block_count == 11'd0)
        else $error("allocate result carries check totals");
endmodule

bind boundary_tag_heap_allocator btha_checker u_btha_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_status          (o_status),
    .o_granted_offset  (o_granted_offset),
    .o_free_block_count(o_free_block_count),
    .o_used_block_count(o_used_block_count)
);
`default_nettype wire
